// ===== design/frw_pkg.sv =====
`timescale 1ns / 1ps
// frw_pkg: shared types, constants and link classification for the fat12 run walker
// no dependencies

package frw_pkg;

  localparam int TABLE_BYTES_DEF = 8192;
  localparam int CLUSTER_W       = 12;
  localparam int BYTE_AW         = 13;

  localparam logic [11:0] DATA_LOW  = 12'h002;
  localparam logic [11:0] DATA_HIGH = 12'hfef;
  localparam logic [11:0] RSVD_LOW  = 12'hff0;
  localparam logic [11:0] RSVD_HIGH = 12'hff6;
  localparam logic [11:0] BAD_LINK  = 12'hff7;
  localparam logic [11:0] EOF_LOW   = 12'hff8;

  localparam logic [1:0] END_DATA = 2'd0;
  localparam logic [1:0] END_EOF  = 2'd1;
  localparam logic [1:0] END_BAD  = 2'd2;
  localparam logic [1:0] END_RSVD = 2'd3;

  localparam logic CFG_DATA_START = 1'b0;
  localparam logic CFG_SPC        = 1'b1;

  // one table byte write
  typedef struct packed {
    logic               en;
    logic [BYTE_AW-1:0] addr;
    logic [7:0]         data;
  } tbl_wr_t;

  function automatic logic is_data(input logic [11:0] c);
    is_data = (c >= DATA_LOW) && (c <= DATA_HIGH);
  endfunction

  function automatic logic is_eof(input logic [11:0] c);
    is_eof = (c >= EOF_LOW);
  endfunction

  function automatic logic [1:0] end_class(input logic [11:0] c);
    if (is_eof(c)) begin
      end_class = END_EOF;
    end else if (c == BAD_LINK) begin
      end_class = END_BAD;
    end else if ((c >= RSVD_LOW) && (c <= RSVD_HIGH)) begin
      end_class = END_RSVD;
    end else begin
      end_class = END_DATA;
    end
  endfunction

endpackage

// ===== design/fat12_chain_run_walker.sv =====
`timescale 1ns / 1ps
// fat12_chain_run_walker: top level, query sequencer, run lba and result register
// depends on frw_pkg, frw_table (and through it frw_ram)

// A load word writes one table byte. A query word on a data cluster is accepted and
// issues the first read, then visits the run's table entries in turn (the table is split
// into even and odd byte banks so that a whole 12-bit entry comes back each cycle
// from the synchronous memory), and then builds the result into the output register.
// A query on a non-data start goes from acceptance straight to building the result.
// Only one word is in work at a time; the next is taken once the result sits in the
// output register. The table needs no clearing after reset; reading a byte that was
// never loaded gives an undefined link. cfg_ready is always high.

module fat12_chain_run_walker #(
  parameter int TABLE_BYTES = frw_pkg::TABLE_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_kind,
  input  logic [frw_pkg::BYTE_AW-1:0]   in_byte_index,
  input  logic [7:0]                    in_byte_value,
  input  logic [frw_pkg::CLUSTER_W-1:0] in_start_cluster,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [11:0]                   out_run_length,
  output logic [11:0]                   out_next_link,
  output logic [1:0]                    out_end_kind,
  output logic [31:0]                   out_run_lba,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_index,
  input  logic [31:0]                   cfg_data
);
  import frw_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WALK = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]         state_r, state_nxt;
  logic [11:0]        cur_r, cur_nxt;
  logic [11:0]        count_r, count_nxt;
  logic [11:0]        next_r, next_nxt;
  logic signed [21:0] prod_r, prod_nxt;
  logic [31:0]        dsl_r;
  logic [7:0]         spc_r;
  logic               out_valid_r, out_valid_nxt;
  logic [11:0]        out_len_r, out_len_nxt;
  logic [11:0]        out_link_r, out_link_nxt;
  logic [1:0]         out_kind_r, out_kind_nxt;
  logic [31:0]        out_lba_r, out_lba_nxt;

  logic               in_acc;
  logic               walk_go;
  logic               out_load;
  logic [12:0]        start_diff;
  logic [11:0]        rd_cluster;
  logic [11:0]        entry;
  tbl_wr_t            tbl_wr;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign tbl_wr.en   = in_acc && !in_kind;
  assign tbl_wr.addr = in_byte_index;
  assign tbl_wr.data = in_byte_value;

  frw_table #(
    .TABLE_BYTES (TABLE_BYTES)
  ) u_table (
    .clk        (clk),
    .wr         (tbl_wr),
    .rd_cluster (rd_cluster),
    .entry      (entry)
  );

  // (start - 2) * spc, sign carried so the 32-bit wrap of small starts comes out right
  assign start_diff = {1'b0, in_start_cluster} - 13'd2;

  // continue while the link is the next cluster and still a data cluster
  assign walk_go  = (entry == cur_r + 12'd1) && is_data(entry);
  assign out_load = (state_r == ST_FIN) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    count_nxt     = count_r;
    next_nxt      = next_r;
    prod_nxt      = prod_r;
    rd_cluster    = in_start_cluster;
    out_valid_nxt = out_valid_r && out_stall;
    out_len_nxt   = out_len_r;
    out_link_nxt  = out_link_r;
    out_kind_nxt  = out_kind_r;
    out_lba_nxt   = out_lba_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && in_kind) begin
          cur_nxt   = in_start_cluster;
          count_nxt = 12'd1;
          prod_nxt  = $signed(start_diff) * $signed({1'b0, spc_r});
          if (is_data(in_start_cluster)) begin
            state_nxt = ST_WALK;
          end else begin
            next_nxt  = is_eof(in_start_cluster) ? in_start_cluster : 12'd0;
            state_nxt = ST_FIN;
          end
        end
      end
      ST_WALK: begin
        rd_cluster = entry;
        if (walk_go) begin
          cur_nxt   = entry;
          count_nxt = count_r + 12'd1;
        end else begin
          next_nxt  = entry;
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          out_len_nxt   = count_r;
          out_link_nxt  = next_r;
          out_kind_nxt  = end_class(next_r);
          out_lba_nxt   = dsl_r + {{10{prod_r[21]}}, prod_r};
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      dsl_r       <= 32'd0;
      spc_r       <= 8'd1;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_DATA_START: dsl_r <= cfg_data;
          CFG_SPC:        spc_r <= cfg_data[7:0];
          default:        ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    count_r    <= count_nxt;
    next_r     <= next_nxt;
    prod_r     <= prod_nxt;
    out_len_r  <= out_len_nxt;
    out_link_r <= out_link_nxt;
    out_kind_r <= out_kind_nxt;
    out_lba_r  <= out_lba_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_run_length = out_len_r;
  assign out_next_link  = out_link_r;
  assign out_end_kind   = out_kind_r;
  assign out_run_lba    = out_lba_r;

  a_walk_on_data: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) |-> is_data(cur_r))
    else $error("walk on a non-data cluster");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK && walk_go) |=> (count_r == $past(count_r) + 12'd1))
    else $error("run count did not advance");

  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_FIN))
    else $error("result loaded outside finish step");

  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_len_r != 12'd0))
    else $error("zero run length");

endmodule

// ===== design/frw_ram.sv =====
`timescale 1ns / 1ps
// frw_ram: generic simple dual-port ram, one write port, one registered read port
// no dependencies

module frw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/frw_table.sv =====
`timescale 1ns / 1ps
// frw_table: fat12 table store split into even and odd byte banks so one 12-bit entry
// is read per cycle; depends on frw_pkg and frw_ram

module frw_table #(
  parameter int TABLE_BYTES = frw_pkg::TABLE_BYTES_DEF
) (
  input  logic                             clk,
  input  frw_pkg::tbl_wr_t                 wr,
  input  logic [frw_pkg::CLUSTER_W-1:0]    rd_cluster,
  output logic [frw_pkg::CLUSTER_W-1:0]    entry
);
  import frw_pkg::*;

  localparam int EVEN_DEPTH = (TABLE_BYTES + 1) / 2;
  localparam int ODD_DEPTH  = TABLE_BYTES / 2;
  localparam int EVEN_AW    = $clog2(EVEN_DEPTH);
  localparam int ODD_AW     = $clog2(ODD_DEPTH);

  logic        wr_in_range;
  logic [11:0] wr_half;
  logic [12:0] off;
  logic [13:0] off_ext;
  logic [11:0] half;
  logic [11:0] ev_ridx;
  logic        lo_ok;
  logic        hi_ok;
  logic [7:0]  ev_q;
  logic [7:0]  od_q;
  logic        off_odd_r;
  logic        lo_ok_r;
  logic        hi_ok_r;
  logic        c_odd_r;
  logic [7:0]  lo_byte;
  logic [7:0]  hi_byte;
  logic [15:0] word;

  assign wr_in_range = {1'b0, wr.addr} < 14'(TABLE_BYTES);
  assign wr_half     = wr.addr[12:1];

  // byte offset of the entry is c + c/2
  assign off     = {1'b0, rd_cluster} + {2'b00, rd_cluster[11:1]};
  assign off_ext = {1'b0, off};
  assign half    = off[12:1];
  assign ev_ridx = off[0] ? half + 12'd1 : half;
  assign lo_ok   = off_ext < 14'(TABLE_BYTES);
  assign hi_ok   = (off_ext + 14'd1) < 14'(TABLE_BYTES);

  frw_ram #(
    .WIDTH (8),
    .DEPTH (EVEN_DEPTH)
  ) u_even (
    .clk   (clk),
    .we    (wr.en && wr_in_range && !wr.addr[0]),
    .waddr (wr_half[EVEN_AW-1:0]),
    .wdata (wr.data),
    .raddr (ev_ridx[EVEN_AW-1:0]),
    .rdata (ev_q)
  );

  frw_ram #(
    .WIDTH (8),
    .DEPTH (ODD_DEPTH)
  ) u_odd (
    .clk   (clk),
    .we    (wr.en && wr_in_range && wr.addr[0]),
    .waddr (wr_half[ODD_AW-1:0]),
    .wdata (wr.data),
    .raddr (half[ODD_AW-1:0]),
    .rdata (od_q)
  );

  always_ff @(posedge clk) begin
    off_odd_r <= off[0];
    lo_ok_r   <= lo_ok;
    hi_ok_r   <= hi_ok;
    c_odd_r   <= rd_cluster[0];
  end

  // bytes past the end of the table read as zero
  assign lo_byte = lo_ok_r ? (off_odd_r ? od_q : ev_q) : 8'h00;
  assign hi_byte = hi_ok_r ? (off_odd_r ? ev_q : od_q) : 8'h00;
  assign word    = {hi_byte, lo_byte};
  assign entry   = c_odd_r ? word[15:4] : word[11:0];

endmodule

// ===== tb/tb_fat12_chain_run_walker.sv =====
`timescale 1ns / 1ps
// tb_fat12_chain_run_walker: self-checking bench for the fat12 chain run walker
// depends on frw_pkg and fat12_chain_run_walker; keeps its own shadow of the table

module tb_fat12_chain_run_walker;
  import frw_pkg::*;

  localparam int TBL_BYTES    = TABLE_BYTES_DEF;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASES       = 6;
  localparam int PHASE_WORDS  = 180;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic [11:0] run_length;
    logic [11:0] next_link;
    logic [1:0]  end_kind;
    logic [31:0] run_lba;
  } run_t;

  typedef struct packed {
    logic        op;
    logic [12:0] idx;
    logic [7:0]  val;
    logic [11:0] sc;
    logic        typed;
    run_t        want;
  } row_t;

  localparam run_t NO_RUN = '0;
  localparam int DIR_ROWS = 24;

  // directed words; typed rows assume register values after reset
  row_t dir_rows [DIR_ROWS] = '{
    '{OP_LOAD,  13'd0,    8'h00, 12'h000, 1'b0, '0},
    '{OP_LOAD,  13'd8191, 8'hff, 12'hfff, 1'b0, '0},
    '{OP_QUERY, 13'd0,    8'h00, 12'h000, 1'b1, '{12'd1, 12'h000, END_DATA, 32'hffff_fffe}},
    '{OP_QUERY, 13'd8191, 8'hff, 12'h001, 1'b1, '{12'd1, 12'h000, END_DATA, 32'hffff_ffff}},
    '{OP_QUERY, 13'd0,    8'h00, 12'hff0, 1'b1, '{12'd1, 12'h000, END_DATA, 32'h0000_0fee}},
    '{OP_QUERY, 13'd0,    8'h00, 12'hff7, 1'b1, '{12'd1, 12'h000, END_DATA, 32'h0000_0ff5}},
    '{OP_QUERY, 13'd0,    8'h00, 12'hff8, 1'b1, '{12'd1, 12'hff8, END_EOF, 32'h0000_0ff6}},
    '{OP_QUERY, 13'd0,    8'h00, 12'hfff, 1'b1, '{12'd1, 12'hfff, END_EOF, 32'h0000_0ffd}},
    // clusters 2 -> 3 -> 4 -> end of file
    '{OP_LOAD,  13'd3,    8'h03, 12'h000, 1'b0, '0},
    '{OP_LOAD,  13'd4,    8'h40, 12'h000, 1'b0, '0},
    '{OP_LOAD,  13'd5,    8'h00, 12'h000, 1'b0, '0},
    '{OP_LOAD,  13'd6,    8'hff, 12'h000, 1'b0, '0},
    '{OP_LOAD,  13'd7,    8'h0f, 12'h000, 1'b0, '0},
    '{OP_QUERY, 13'd0,    8'h00, 12'h002, 1'b1, '{12'd3, 12'hfff, END_EOF, 32'h0000_0000}},
    '{OP_QUERY, 13'd0,    8'h00, 12'h003, 1'b0, '0},
    '{OP_QUERY, 13'd0,    8'h00, 12'h004, 1'b1, '{12'd1, 12'hfff, END_EOF, 32'h0000_0002}},
    // last data cluster points at the bad marker
    '{OP_LOAD,  13'd6118, 8'h70, 12'h000, 1'b0, '0},
    '{OP_LOAD,  13'd6119, 8'hff, 12'h000, 1'b0, '0},
    '{OP_QUERY, 13'd0,    8'h00, 12'hfef, 1'b1, '{12'd1, 12'hff7, END_BAD, 32'h0000_0fed}},
    // cluster 0x10 reserved, cluster 0x11 jumps away
    '{OP_LOAD,  13'd24,   8'hf0, 12'h000, 1'b0, '0},
    '{OP_LOAD,  13'd25,   8'h0f, 12'h000, 1'b0, '0},
    '{OP_LOAD,  13'd26,   8'h20, 12'h000, 1'b0, '0},
    '{OP_QUERY, 13'd0,    8'h00, 12'h010, 1'b1, '{12'd1, 12'hff0, END_RSVD, 32'h0000_000e}},
    '{OP_QUERY, 13'd0,    8'h00, 12'h011, 1'b1, '{12'd1, 12'h200, END_DATA, 32'h0000_000f}}
  };

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_kind;
  logic [12:0] in_byte_index;
  logic [7:0]  in_byte_value;
  logic [11:0] in_start_cluster;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [11:0] out_run_length;
  logic [11:0] out_next_link;
  logic [1:0]  out_end_kind;
  logic [31:0] out_run_lba;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [31:0] cfg_data;

  // shadow of the table and registers
  logic [7:0]  fat_mem [TBL_BYTES];
  bit          fat_loaded [TBL_BYTES];
  logic [31:0] cfg_lba;
  logic [7:0]  cfg_spc;

  run_t pending_runs [$];
  int   err_count = 0;
  int   words_sent = 0;
  bit   tx_calm = 1'b0;
  int   rx_taken = 0;
  int   rx_seen = 0;
  int   rx_hold = 0;
  bit   rx_calm = 1'b0;

  fat12_chain_run_walker u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_byte_index    (in_byte_index),
    .in_byte_value    (in_byte_value),
    .in_start_cluster (in_start_cluster),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_run_length   (out_run_length),
    .out_next_link    (out_next_link),
    .out_end_kind     (out_end_kind),
    .out_run_lba      (out_run_lba),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(10_000_000);
    $display("DONE: errors detected");
    $finish;
  end

  function automatic bit data_link(input logic [11:0] v);
    return (v >= DATA_LOW) && (v <= DATA_HIGH);
  endfunction

  function automatic logic [1:0] link_class(input logic [11:0] v);
    if (v >= EOF_LOW) return END_EOF;
    if (v == BAD_LINK) return END_BAD;
    if ((v >= RSVD_LOW) && (v <= RSVD_HIGH)) return END_RSVD;
    return END_DATA;
  endfunction

  // follows the contiguous run from start; hole gets the first unloaded byte it needs
  function automatic void walk_chain(input logic [11:0] start, output run_t r,
                                     output int hole);
    logic [11:0] cur;
    logic [11:0] nxt;
    logic [11:0] count;
    logic [15:0] w;
    int          off;
    bit          going;
    hole  = -1;
    cur   = start;
    nxt   = '0;
    count = '0;
    going = 1'b1;
    while (going) begin
      count++;
      if (cur >= EOF_LOW) begin
        nxt = cur;
      end else if (!data_link(cur)) begin
        nxt = '0;
      end else begin
        off = int'(cur) * 3 / 2;
        if (!fat_loaded[off]) hole = off;
        else if (!fat_loaded[off+1]) hole = off + 1;
        w   = {fat_mem[off+1], fat_mem[off]};
        nxt = cur[0] ? w[15:4] : w[11:0];
      end
      if (hole >= 0) going = 1'b0;
      else if (({1'b0, nxt} != {1'b0, cur} + 13'd1) || !data_link(nxt)) going = 1'b0;
      else cur = nxt;
    end
    r.run_length = count;
    r.next_link  = nxt;
    r.end_kind   = link_class(nxt);
    r.run_lba    = cfg_lba + ({20'd0, start} - 32'd2) * {24'd0, cfg_spc};
  endfunction

  // called at a falling edge; returns at the falling edge after the word is taken
  task automatic send_word(input logic op, input logic [12:0] idx, input logic [7:0] val,
                           input logic [11:0] sc, input logic typed, input run_t want);
    int   gap;
    int   hole;
    run_t r;
    gap = tx_calm ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_kind          <= op;
    in_byte_index    <= idx;
    in_byte_value    <= val;
    in_start_cluster <= sc;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (op == OP_LOAD) begin
      fat_mem[idx]    = val;
      fat_loaded[idx] = 1'b1;
    end else begin
      if (typed) r = want;
      else walk_chain(sc, r, hole);
      pending_runs.push_back(r);
    end
    words_sent++;
    @(negedge clk);
  endtask

  task automatic load_byte(input logic [12:0] idx, input logic [7:0] val);
    send_word(OP_LOAD, idx, val, 12'($urandom), 1'b0, NO_RUN);
  endtask

  // fill any table byte the walk would touch before it was loaded
  task automatic ask_run(input logic [11:0] sc);
    run_t r;
    int   hole;
    walk_chain(sc, r, hole);
    while (hole >= 0) begin
      load_byte(13'(hole), 8'($urandom));
      walk_chain(sc, r, hole);
    end
    send_word(OP_QUERY, 13'($urandom), 8'($urandom), sc, 1'b0, NO_RUN);
  endtask

  // two byte loads per entry, keeping the neighbor's nibble
  task automatic put_entry(input logic [11:0] c, input logic [11:0] v);
    int         off;
    logic [7:0] b0;
    logic [7:0] b1;
    off = int'(c) * 3 / 2;
    b0  = fat_loaded[off] ? fat_mem[off] : 8'($urandom);
    b1  = fat_loaded[off+1] ? fat_mem[off+1] : 8'($urandom);
    if (!c[0]) begin
      b0 = v[7:0];
      b1 = {b1[7:4], v[11:8]};
    end else begin
      b0 = {v[3:0], b0[3:0]};
      b1 = v[11:4];
    end
    load_byte(13'(off), b0);
    load_byte(13'(off + 1), b1);
  endtask

  // lay down a contiguous run with a random terminator, then query it
  task automatic build_run();
    int          len;
    int          s;
    int          c;
    int          skip;
    logic [11:0] term;
    len = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 60) : $urandom_range(1, 8);
    case ($urandom_range(0, 9))
      0: begin
        s = 'hfef - len + 1;
      end
      1: begin
        s = 2;
      end
      default: begin
        s = $urandom_range(2, 'hfef - len + 1);
      end
    endcase
    case ($urandom_range(0, 5))
      0: term = 12'($urandom_range('hff8, 'hfff));
      1: term = BAD_LINK;
      2: term = 12'($urandom_range('hff0, 'hff6));
      3: term = 12'($urandom_range(0, 1));
      4: term = 12'($urandom_range('h002, 'hfef));
      default: term = 12'(s + len);
    endcase
    // now and then leave one entry out so the query hits stale or fresh bytes
    skip = ($urandom_range(0, 9) == 0) ? s + $urandom_range(0, len - 1) : -1;
    for (c = s; c < s + len; c++) begin
      if (c != skip) begin
        put_entry(12'(c), (c == s + len - 1) ? term : 12'(c + 1));
      end
    end
    ask_run(12'(s));
    if ((len > 1) && ($urandom_range(0, 1) == 1)) begin
      ask_run(12'(s + $urandom_range(1, len - 1)));
    end
  endtask

  task automatic run_phase(input int target);
    int first;
    int pick;
    first = words_sent;
    while (words_sent - first < target) begin
      tx_calm = ($urandom_range(0, 5) == 0);
      pick = $urandom_range(0, 19);
      if (pick < 12) build_run();
      else if (pick < 17) ask_run(12'($urandom));
      else load_byte(13'($urandom), 8'($urandom));
    end
    in_valid <= 1'b0;
  endtask

  // sender stays quiet until every result is back, then lets the last load finish
  task automatic settle();
    while (pending_runs.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_regs(input logic [31:0] lba, input logic [31:0] spc_word);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_DATA_START;
    cfg_data  <= lba;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_lba = lba;
    @(negedge clk);
    cfg_index <= CFG_SPC;
    cfg_data  <= spc_word;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_spc = spc_word[7:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      err_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    run_t want;
    if (rst_n && out_valid && !out_stall) begin
      rx_taken++;
      if (pending_runs.size() == 0) begin
        err_count++;
        $display("%0t: unexpected word, expected none, actual %h %h %h %h", $time,
                 out_run_length, out_next_link, out_end_kind, out_run_lba);
      end else begin
        want = pending_runs.pop_front();
        check_field("run_length", {20'd0, want.run_length}, {20'd0, out_run_length});
        check_field("next_link", {20'd0, want.next_link}, {20'd0, out_next_link});
        check_field("end_kind", {30'd0, want.end_kind}, {30'd0, out_end_kind});
        check_field("run_lba", want.run_lba, out_run_lba);
      end
    end
  end

  // receiver raises out_stall for a random hold after each word, with calm stretches
  always @(negedge clk) begin
    if (rx_seen != rx_taken) begin
      rx_seen = rx_taken;
      rx_hold = rx_calm ? 0 : $urandom_range(0, 7);
      if ($urandom_range(0, 29) == 0) rx_calm = !rx_calm;
    end
    if (rx_hold > 0) begin
      out_stall <= 1'b1;
      rx_hold--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  initial begin
    logic [31:0] ph_lba [PHASES];
    logic [7:0]  ph_spc [PHASES];
    int          i;
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_kind          = OP_LOAD;
    in_byte_index    = '0;
    in_byte_value    = '0;
    in_start_cluster = '0;
    cfg_valid        = 1'b0;
    cfg_index        = CFG_DATA_START;
    cfg_data         = '0;
    cfg_lba          = '0;
    cfg_spc          = 8'd1;
    ph_lba = '{32'hffff_ffff, 32'h0, $urandom, $urandom, $urandom, 32'h8000_0000};
    ph_spc = '{8'd128, 8'd1, 8'd0, 8'd255, 8'($urandom_range(1, 128)),
               8'($urandom_range(1, 128))};
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (i = 0; i < DIR_ROWS; i++) begin
      send_word(dir_rows[i].op, dir_rows[i].idx, dir_rows[i].val, dir_rows[i].sc,
                dir_rows[i].typed, dir_rows[i].want);
    end
    in_valid <= 1'b0;
    settle();

    for (i = 0; i < PHASES; i++) begin
      // upper bits of the sectors word are noise the block must drop
      write_regs(ph_lba[i], {24'($urandom), ph_spc[i]});
      run_phase(PHASE_WORDS);
      settle();
    end

    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
